@@ rtl/scbpa_pkg.sv @@
// Package for the size-class block pool allocator.
// Holds pool geometry, status codes, FSM states and shared types.
// No dependencies.
package scbpa_pkg;

   localparam int BLOCKS_PER_POOL   = 255;
   localparam int POOL_COUNT        = 3;
   localparam int SMALLEST_SHIFT    = 4;                      // 16-byte blocks
   localparam int STACK_DEPTH       = POOL_COUNT * BLOCKS_PER_POOL;
   localparam int STACK_ADDR_WIDTH  = $clog2(STACK_DEPTH);
   localparam int POOL_INDEX_WIDTH  = (POOL_COUNT > 1) ? $clog2(POOL_COUNT) : 1;
   localparam int BLOCK_INDEX_WIDTH = 8;
   localparam int ADDR_WIDTH        = 32;
   localparam int REQ_BYTES_WIDTH   = 16;
   localparam int HEADER_WIDTH      = 4;
   localparam int CSR_INDEX_WIDTH   = 2;
   localparam int CSR_DATA_WIDTH    = 32;

   localparam logic [HEADER_WIDTH-1:0] HEADER_RESET = HEADER_WIDTH'(8);

   typedef logic [POOL_INDEX_WIDTH-1:0]  pool_index_type;
   typedef logic [BLOCK_INDEX_WIDTH-1:0] block_index_type;
   typedef logic [STACK_ADDR_WIDTH-1:0]  stack_addr_type;
   typedef logic [ADDR_WIDTH-1:0]        addr_type;

   typedef enum logic [0:0] {
      OP_ALLOC = 1'b0,
      OP_FREE  = 1'b1
   } op_type;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_NO_FIT   = 3'd1,
      ST_EMPTY    = 3'd2,
      ST_BAD_ADDR = 3'd3,
      ST_FULL     = 3'd4
   } status_type;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_POOL_BASE = CSR_INDEX_WIDTH'(0),
      CSR_HEADER    = CSR_INDEX_WIDTH'(1)
   } csr_index_type;

   typedef enum logic [0:0] {
      FSM_IDLE = 1'b0,
      FSM_EXEC = 1'b1
   } fsm_type;

   // Block size in bytes of pool p.
   function automatic addr_type block_size(input int p);
      return addr_type'(1) << (SMALLEST_SHIFT + p);
   endfunction

   // Bytes taken by pool p as a whole.
   function automatic addr_type pool_span(input int p);
      return block_size(p) * addr_type'(BLOCKS_PER_POOL);
   endfunction

   // Byte offset of pool p from the pool base address.
   function automatic addr_type pool_offset(input int p);
      addr_type off;
      off = '0;
      for (int q = 0; q < p; q++) begin
         off = off + pool_span(q);
      end
      return off;
   endfunction

endpackage

@@ rtl/scbpa_if.sv @@
// Channel interfaces for the size-class block pool allocator.
// Request, response and register-write channels, valid/ready handshake.
// Depends on scbpa_pkg.
interface scbpa_req_if import scbpa_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic                       op;
   logic [REQ_BYTES_WIDTH-1:0] request_bytes;
   logic [ADDR_WIDTH-1:0]      block_address;

   modport source (output valid, op, request_bytes, block_address, input ready);
   modport sink   (input valid, op, request_bytes, block_address, output ready);
endinterface

interface scbpa_rsp_if import scbpa_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [ADDR_WIDTH-1:0] granted_address;
   logic [2:0]            status;

   modport source (output valid, granted_address, status, input ready);
   modport sink   (input valid, granted_address, status, output ready);
endinterface

interface scbpa_csr_if import scbpa_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic [CSR_INDEX_WIDTH-1:0] index;
   logic [CSR_DATA_WIDTH-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/scbpa_stack_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// Holds the freed-block stacks. No dependencies.
module scbpa_stack_ram #(
   parameter int DEPTH = 765,
   parameter int WIDTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/size_class_block_pool_allocator_core.sv @@
// Size-class block pool allocator: 16/32/64-byte pools with LIFO free stacks.
// Response: the request is registered at accept and executed in the EXEC state once
// the response register is free; a new request is taken only back in IDLE, after the
// stack RAM read at accept and the stack update in the EXEC state.
// Reset (synchronous, active high): fresh counts and stack depths cleared,
// base address 0, header 8 bytes; the stack RAM is not cleared.
// Depends on scbpa_pkg, scbpa_if and scbpa_stack_ram.
module size_class_block_pool_allocator_core
   import scbpa_pkg::*;
(
   input  logic   clock,
   input  logic   reset,
   scbpa_req_if.sink   req_bus,
   scbpa_rsp_if.source rsp_bus,
   scbpa_csr_if.sink   csr_bus
);

   // ---------------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------------
   addr_type                base_ff;
   logic [HEADER_WIDTH-1:0] header_ff;

   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff   <= '0;
         header_ff <= HEADER_RESET;
      end else if (csr_bus.valid) begin
         case (csr_bus.index)
            CSR_POOL_BASE: base_ff   <= ADDR_WIDTH'(csr_bus.data);
            CSR_HEADER:    header_ff <= csr_bus.data[HEADER_WIDTH-1:0];
            default:       ;   // unknown index: dropped
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Pool state
   // ---------------------------------------------------------------------
   block_index_type fresh_ff [POOL_COUNT];
   block_index_type depth_ff [POOL_COUNT];
   block_index_type fresh_in [POOL_COUNT];
   block_index_type depth_in [POOL_COUNT];

   // ---------------------------------------------------------------------
   // Control
   // ---------------------------------------------------------------------
   fsm_type state_ff, state_in;
   logic    req_fire;
   logic    exec_fire;
   logic    rsp_free;

   assign req_fire  = req_bus.valid && req_bus.ready;
   assign rsp_free  = !rsp_bus.valid || rsp_bus.ready;
   assign exec_fire = (state_ff == FSM_EXEC) && rsp_free;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         FSM_IDLE: if (req_fire)  state_in = FSM_EXEC;
         FSM_EXEC: if (exec_fire) state_in = FSM_IDLE;
         default:  state_in = FSM_IDLE;
      endcase
   end

   always_comb begin
      case (state_ff)
         FSM_IDLE: req_bus.ready = 1'b1;
         default:  req_bus.ready = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FSM_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // ---------------------------------------------------------------------
   // Accept cycle: size-class decode and stack-top read for an allocate.
   // The read is issued whatever the op; only an allocate uses the data.
   // ---------------------------------------------------------------------
   logic [REQ_BYTES_WIDTH:0] need;
   logic                     fit_in;
   pool_index_type           class_in;
   stack_addr_type           pop_addr;

   assign need = {1'b0, req_bus.request_bytes} + (REQ_BYTES_WIDTH+1)'(header_ff);

   always_comb begin
      fit_in   = 1'b0;
      class_in = '0;
      // Scan from the top so the smallest fitting class wins.
      for (int p = POOL_COUNT - 1; p >= 0; p--) begin
         if (ADDR_WIDTH'(need) <= block_size(p)) begin
            fit_in   = 1'b1;
            class_in = POOL_INDEX_WIDTH'(p);
         end
      end
   end

   always_comb begin
      pop_addr = STACK_ADDR_WIDTH'(class_in) * STACK_ADDR_WIDTH'(BLOCKS_PER_POOL);
      if (depth_ff[class_in] != '0) begin
         pop_addr = pop_addr + STACK_ADDR_WIDTH'(depth_ff[class_in])
                    - STACK_ADDR_WIDTH'(1);
      end
   end

   // Request register
   logic           op_ff;
   addr_type       addr_ff;
   logic           fit_ff;
   pool_index_type class_ff;

   always_ff @(posedge clock) begin
      if (req_fire) begin
         op_ff    <= req_bus.op;
         addr_ff  <= req_bus.block_address;
         fit_ff   <= fit_in;
         class_ff <= class_in;
      end
   end

   // ---------------------------------------------------------------------
   // Free-address decode: offset from the first pool, then range per pool
   // ---------------------------------------------------------------------
   addr_type        free_off;
   addr_type        free_rel;
   logic            free_found;
   pool_index_type  free_class;
   logic            free_aligned;
   block_index_type free_index;

   assign free_off = addr_ff - ADDR_WIDTH'(header_ff) - base_ff;

   always_comb begin
      free_found   = 1'b0;
      free_class   = '0;
      free_rel     = '0;
      free_aligned = 1'b0;
      free_index   = '0;
      for (int p = POOL_COUNT - 1; p >= 0; p--) begin
         if (free_off >= pool_offset(p) && (free_off - pool_offset(p)) < pool_span(p)) begin
            free_found   = 1'b1;
            free_class   = POOL_INDEX_WIDTH'(p);
            free_rel     = free_off - pool_offset(p);
            free_aligned = (free_rel & (block_size(p) - addr_type'(1))) == '0;
            free_index   = BLOCK_INDEX_WIDTH'(free_rel >> (SMALLEST_SHIFT + p));
         end
      end
   end

   // ---------------------------------------------------------------------
   // Execute cycle: stack/fresh update and response
   // ---------------------------------------------------------------------
   block_index_type stack_q;
   block_index_type grant_index;
   status_type      status_in;
   addr_type        granted_in;
   logic            push_en;
   stack_addr_type  push_addr;
   addr_type        class_offset;

   always_comb begin
      for (int p = 0; p < POOL_COUNT; p++) begin
         fresh_in[p] = fresh_ff[p];
         depth_in[p] = depth_ff[p];
      end
      grant_index = '0;
      status_in   = ST_OK;
      push_en     = 1'b0;
      push_addr   = STACK_ADDR_WIDTH'(free_class) * STACK_ADDR_WIDTH'(BLOCKS_PER_POOL)
                    + STACK_ADDR_WIDTH'(depth_ff[free_class]);
      if (op_ff == OP_ALLOC) begin
         if (!fit_ff) begin
            status_in = ST_NO_FIT;
         end else if (depth_ff[class_ff] != '0) begin
            // LIFO: most recently freed block first
            grant_index          = stack_q;
            depth_in[class_ff]   = depth_ff[class_ff] - BLOCK_INDEX_WIDTH'(1);
         end else if (32'(fresh_ff[class_ff]) < BLOCKS_PER_POOL) begin
            grant_index          = fresh_ff[class_ff];
            fresh_in[class_ff]   = fresh_ff[class_ff] + BLOCK_INDEX_WIDTH'(1);
         end else begin
            status_in = ST_EMPTY;
         end
      end else begin
         if (!free_found || !free_aligned) begin
            status_in = ST_BAD_ADDR;
         end else if (32'(depth_ff[free_class]) >= BLOCKS_PER_POOL) begin
            status_in = ST_FULL;
         end else begin
            push_en              = 1'b1;
            depth_in[free_class] = depth_ff[free_class] + BLOCK_INDEX_WIDTH'(1);
         end
      end
   end

   always_comb begin
      class_offset = '0;
      for (int p = 0; p < POOL_COUNT; p++) begin
         if (class_ff == POOL_INDEX_WIDTH'(p)) begin
            class_offset = pool_offset(p);
         end
      end
   end

   always_comb begin
      granted_in = '0;
      if (op_ff == OP_ALLOC && status_in == ST_OK) begin
         granted_in = base_ff + class_offset
                      + (ADDR_WIDTH'(grant_index) << (SMALLEST_SHIFT + 32'(class_ff)))
                      + ADDR_WIDTH'(header_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int p = 0; p < POOL_COUNT; p++) begin
            fresh_ff[p] <= '0;
            depth_ff[p] <= '0;
         end
      end else if (exec_fire) begin
         for (int p = 0; p < POOL_COUNT; p++) begin
            fresh_ff[p] <= fresh_in[p];
            depth_ff[p] <= depth_in[p];
         end
      end
   end

   scbpa_stack_ram #(
      .DEPTH (STACK_DEPTH),
      .WIDTH (BLOCK_INDEX_WIDTH)
   ) u_stack_ram (
      .clock   (clock),
      .wr_en   (exec_fire && push_en),
      .wr_addr (push_addr),
      .wr_data (free_index),
      .rd_en   (req_fire),
      .rd_addr (pop_addr),
      .rd_data (stack_q)
   );

   // ---------------------------------------------------------------------
   // Response register
   // ---------------------------------------------------------------------
   logic       rsp_valid_ff;
   addr_type   granted_ff;
   status_type status_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (exec_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (exec_fire) begin
         granted_ff <= granted_in;
         status_ff  <= status_in;
      end
   end

   assign rsp_bus.valid           = rsp_valid_ff;
   assign rsp_bus.granted_address = granted_ff;
   assign rsp_bus.status          = status_ff;

endmodule
